>>> sv/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants, codes and transaction types for the buffer pool block.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int SLOTS    = 16;
  localparam int PIN_BITS = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [PIN_BITS-1:0] PIN_MAX  = '1;
  localparam logic [31:0]         LSN_NONE = 32'hFFFF_FFFF;

  localparam logic [2:0] ACT_GET       = 3'd0;
  localparam logic [2:0] ACT_UNPIN     = 3'd1;
  localparam logic [2:0] ACT_SET_LSN   = 3'd2;
  localparam logic [2:0] ACT_FLUSH     = 3'd3;
  localparam logic [2:0] ACT_FLUSH_ALL = 3'd4;

  localparam logic [2:0] STAT_DONE      = 3'd0;
  localparam logic [2:0] STAT_HIT       = 3'd1;
  localparam logic [2:0] STAT_LOADED    = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_PINNED    = 3'd4;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_SEARCH = 3'd1,
    OP_GET    = 3'd2,
    OP_SLOT   = 3'd3,
    OP_SWEEP  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] block_key;
    logic [3:0]  slot;
    logic [31:0] lsn;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic        read_needed;
    logic        write_needed;
    logic [31:0] write_block;
    logic        log_flush_needed;
    logic        last;
  } res_t;

  typedef struct packed {
    cell_op_t    op;
    logic [2:0]  action;
    logic [31:0] key;
    logic [3:0]  slot;
    logic [31:0] lsn;
    logic        any_hit;
    logic        any_inv;
  } cell_cmd_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic              valid;
    logic              dirty;
    logic              pins_zero;
    logic [31:0]       block;
    logic              lsn_none;
  } rec_t;

  typedef struct packed {
    logic hit_seen;
    logic inv_seen;
    logic free_seen;
    logic cand_seen;
    rec_t rec;
  } chain_t;

endpackage

>>> sv/bpp_cell.sv
// ----------------------------------------------------------------------------
// bpp_cell
// One buffer slot: holds its entry and takes part in the priority chain.
// ----------------------------------------------------------------------------
module bpp_cell import bpp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  cell_cmd_t         cmd,
  input  chain_t            chain_in,
  output chain_t            chain_out
);

  logic                valid_r, valid_nxt;
  logic [31:0]         block_r, block_nxt;
  logic [PIN_BITS-1:0] pins_r, pins_nxt;
  logic                dirty_r, dirty_nxt;
  logic [31:0]         lsn_r, lsn_nxt;
  logic                sel_hit_r, sel_hit_nxt;
  logic                sel_inv_r, sel_inv_nxt;
  logic                sel_free_r, sel_free_nxt;

  logic hit;
  logic free;
  logic cand;
  logic addr_hit;
  logic chosen;

  assign hit      = valid_r && (block_r == cmd.key);
  assign free     = (pins_r == '0);
  assign cand     = valid_r && dirty_r && free;
  assign addr_hit = (32'(cell_idx) == 32'(cmd.slot));

  always_comb begin
    case (cmd.op)
      OP_GET: begin
        if (cmd.any_hit) begin
          chosen = sel_hit_r;
        end else if (cmd.any_inv) begin
          chosen = sel_inv_r;
        end else begin
          chosen = sel_free_r;
        end
      end
      OP_SLOT:  chosen = addr_hit;
      OP_SWEEP: chosen = cand && !chain_in.cand_seen;
      default:  chosen = 1'b0;
    endcase
  end

  always_comb begin
    valid_nxt    = valid_r;
    block_nxt    = block_r;
    pins_nxt     = pins_r;
    dirty_nxt    = dirty_r;
    lsn_nxt      = lsn_r;
    sel_hit_nxt  = sel_hit_r;
    sel_inv_nxt  = sel_inv_r;
    sel_free_nxt = sel_free_r;
    case (cmd.op)
      OP_SEARCH: begin
        sel_hit_nxt  = hit && !chain_in.hit_seen;
        sel_inv_nxt  = !valid_r && !chain_in.inv_seen;
        sel_free_nxt = free && !chain_in.free_seen;
      end
      OP_GET: begin
        if (chosen) begin
          if (cmd.any_hit) begin
            if (pins_r != PIN_MAX) begin
              pins_nxt = pins_r + PIN_BITS'(1);
            end
          end else begin
            valid_nxt = 1'b1;
            block_nxt = cmd.key;
            pins_nxt  = PIN_BITS'(1);
            dirty_nxt = 1'b0;
            lsn_nxt   = LSN_NONE;
          end
        end
      end
      OP_SLOT: begin
        if (chosen) begin
          case (cmd.action)
            ACT_UNPIN: begin
              if (!free) begin
                pins_nxt = pins_r - PIN_BITS'(1);
              end
            end
            ACT_SET_LSN: begin
              if (valid_r) begin
                lsn_nxt   = cmd.lsn;
                dirty_nxt = 1'b1;
              end
            end
            ACT_FLUSH: begin
              if (cand) begin
                dirty_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_SWEEP: begin
        if (chosen) begin
          dirty_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pins_r     <= '0;
      dirty_r    <= 1'b0;
      lsn_r      <= LSN_NONE;
      sel_hit_r  <= 1'b0;
      sel_inv_r  <= 1'b0;
      sel_free_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      pins_r     <= pins_nxt;
      dirty_r    <= dirty_nxt;
      lsn_r      <= lsn_nxt;
      sel_hit_r  <= sel_hit_nxt;
      sel_inv_r  <= sel_inv_nxt;
      sel_free_r <= sel_free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    block_r <= block_nxt;
  end

  always_comb begin
    chain_out.hit_seen  = chain_in.hit_seen || hit;
    chain_out.inv_seen  = chain_in.inv_seen || !valid_r;
    chain_out.free_seen = chain_in.free_seen || free;
    chain_out.cand_seen = chain_in.cand_seen || cand;
    if (chosen) begin
      chain_out.rec.found     = 1'b1;
      chain_out.rec.idx       = cell_idx;
      chain_out.rec.valid     = valid_r;
      chain_out.rec.dirty     = dirty_r;
      chain_out.rec.pins_zero = free;
      chain_out.rec.block     = block_r;
      chain_out.rec.lsn_none  = (lsn_r == LSN_NONE);
    end else begin
      chain_out.rec = chain_in.rec;
    end
  end

endmodule

>>> sv/buffer_pool_pin_replace.sv
// ----------------------------------------------------------------------------
// buffer_pool_pin_replace
// Buffer pool slot table that loads the first invalid slot, else replaces the
// first unpinned one, built as a row of slot cells linked by a priority chain.
// A single-result transaction passes the search and execute states, and its
// result is registered as execute ends. One transaction is handled at a time;
// flush all gives one result per cycle, as the chain retires one slot a cycle.
// Reset: synchronous; all slots invalid, unpinned, clean, LSN none; WAL off.
// ----------------------------------------------------------------------------
module buffer_pool_pin_replace import bpp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output res_t out_res,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_EXEC   = 4'b0100,
    ST_SWEEP  = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  req_t      req_r;
  logic      wal_r;
  logic      any_hit_r, any_inv_r;
  logic      out_strobe_r, out_strobe_nxt;
  res_t      out_r, out_nxt;
  cell_cmd_t cmd;
  chain_t    chain [SLOTS+1];
  rec_t      rec;
  logic      oor;
  logic      logf;

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    bpp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(g)),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  assign rec  = chain[SLOTS].rec;
  assign oor  = (32'(req_r.slot) >= 32'(SLOTS));
  assign logf = wal_r && !rec.lsn_none;

  always_comb begin
    cmd.action  = req_r.action;
    cmd.key     = req_r.block_key;
    cmd.slot    = req_r.slot;
    cmd.lsn     = req_r.lsn;
    cmd.any_hit = any_hit_r;
    cmd.any_inv = any_inv_r;
    case (state_r)
      ST_SEARCH: cmd.op = OP_SEARCH;
      ST_EXEC: begin
        if (req_r.action == ACT_GET) begin
          cmd.op = OP_GET;
        end else if (oor) begin
          cmd.op = OP_IDLE;
        end else begin
          cmd.op = OP_SLOT;
        end
      end
      ST_SWEEP: cmd.op = OP_SWEEP;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    out_nxt.last   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_nxt = (req_r.action == ACT_FLUSH_ALL) ? ST_SWEEP : ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
        if (req_r.action > ACT_FLUSH_ALL) begin
          out_nxt.slot_out = '0;
        end else if (req_r.action == ACT_GET) begin
          if (any_hit_r) begin
            out_nxt.status   = STAT_HIT;
            out_nxt.slot_out = 4'(rec.idx);
          end else if (rec.found) begin
            out_nxt.status      = STAT_LOADED;
            out_nxt.slot_out    = 4'(rec.idx);
            out_nxt.read_needed = 1'b1;
            if (rec.valid && rec.dirty) begin
              out_nxt.write_needed     = 1'b1;
              out_nxt.write_block      = rec.block;
              out_nxt.log_flush_needed = logf;
            end
          end else begin
            out_nxt.status = STAT_FULL;
          end
        end else begin
          out_nxt.slot_out = req_r.slot;
          if (!oor) begin
            case (req_r.action)
              ACT_UNPIN: begin
                out_nxt.status = rec.pins_zero ? STAT_UNDERFLOW : STAT_DONE;
              end
              ACT_FLUSH: begin
                if (rec.valid && rec.dirty) begin
                  if (!rec.pins_zero) begin
                    out_nxt.status = STAT_PINNED;
                  end else begin
                    out_nxt.write_needed     = 1'b1;
                    out_nxt.write_block      = rec.block;
                    out_nxt.log_flush_needed = logf;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SWEEP: begin
        out_strobe_nxt = 1'b1;
        if (rec.found) begin
          out_nxt.slot_out         = 4'(rec.idx);
          out_nxt.write_needed     = 1'b1;
          out_nxt.write_block      = rec.block;
          out_nxt.log_flush_needed = logf;
          out_nxt.last             = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wal_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      any_hit_r    <= 1'b0;
      any_inv_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        wal_r <= cfg_wdata;
      end
      if (state_r == ST_SEARCH) begin
        any_hit_r <= chain[SLOTS].hit_seen;
        any_inv_r <= chain[SLOTS].inv_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_IDLE && start) begin
      req_r <= in_req;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

endmodule

>>> sv/bpp_checker.sv
// ----------------------------------------------------------------------------
// bpp_checker
// Port-level checks on the buffer pool command and result timing.
// ----------------------------------------------------------------------------
module bpp_checker import bpp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input res_t out_res
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("result strobe in the cycle after acceptance");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.last |=> !out_strobe)
    else $error("result strobe directly after a last result");

  a_sweep_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last |=> out_strobe)
    else $error("flush-all results not back to back");

  a_log_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.log_flush_needed |-> out_res.write_needed)
    else $error("log flush requested without a writeback");

endmodule

bind buffer_pool_pin_replace bpp_checker u_bpp_checker (.*);
